>>> rtl/tcdr_pkg.sv
// Shared constants, register indexes and reset values for the touch chord recogniser.
package tcdr_pkg;

	localparam int DEF_NUM_LINES = 4;
	localparam int DEF_NUM_CODES = 6;

	localparam int COUNT_W    = 6;
	localparam int TIME_W     = 16;
	localparam int IDX_W      = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 4'd1;
	localparam int                   REG_CODE_BASE = 2;

	localparam logic [COUNT_W-1:0] DEBOUNCE_RST = 6'd32;
	localparam logic [TIME_W-1:0]  SETTLE_RST   = 16'd1000;

	// Reset value of each chord code; codes past the sixth reset to zero.
	function automatic logic [7:0] code_reset(input int idx);
		logic [7:0] val;
		case (idx)
			0: val = 8'd6;
			1: val = 8'd13;
			2: val = 8'd5;
			3: val = 8'd10;
			4: val = 8'd9;
			5: val = 8'd11;
			default: val = 8'd0;
		endcase
		return val;
	endfunction

endpackage

>>> rtl/touch_chord_debounce_recognizer_core.sv
// Touch line debouncer and chord recogniser with stream input and output.
// An accepted input word is registered in the input stage, then its result word in the output stage.
// Throughput: one word per cycle unless the output stalls; debounce, settle and match logic sits in the output stage.
// Reset clears the counters, the debounced vector, the match and settle flags and the pipeline.
// Reset loads the configuration registers with their default values.
module touch_chord_debounce_recognizer_core #(
	parameter int NUM_LINES = tcdr_pkg::DEF_NUM_LINES,
	parameter int NUM_CODES = tcdr_pkg::DEF_NUM_CODES
) (
	input  logic clk,
	input  logic arst_n,
	// raw_lines [NUM_LINES-1:0], now_ms [NUM_LINES+15:NUM_LINES], zero padding above
	input  logic [((NUM_LINES + tcdr_pkg::TIME_W + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	// stable_lines [NUM_LINES-1:0], match_found, match_index (3 bits), zero padding above
	output logic [((NUM_LINES + 1 + tcdr_pkg::IDX_W + 7) / 8) * 8 - 1:0] m_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tcdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcdr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tcdr_pkg::*;

	// Configuration registers.
	logic [COUNT_W-1:0]   debounce_q;
	logic [TIME_W-1:0]    settle_q;
	logic [NUM_LINES-1:0] code_q [NUM_CODES];

	// Recogniser state.
	logic [COUNT_W-1:0]   cnt_q [NUM_LINES];
	logic [NUM_LINES-1:0] stable_q;
	logic                 matched_q;
	logic [TIME_W-1:0]    start_q;
	logic                 settled_q;

	// Input stage.
	logic                 valid_s1;
	logic [NUM_LINES-1:0] raw_s1;
	logic [TIME_W-1:0]    now_s1;

	// Output stage.
	logic                 valid_s2;
	logic [NUM_LINES-1:0] lines_s2;
	logic                 found_s2;
	logic [IDX_W-1:0]     idx_s2;

	logic                 adv;
	logic [COUNT_W-1:0]   cnt_d [NUM_LINES];
	logic [NUM_LINES-1:0] vec_d;
	logic [TIME_W-1:0]    start_d;
	logic [TIME_W-1:0]    elapsed;
	logic                 settled_d;
	logic                 armed;
	logic                 hit;
	logic [IDX_W-1:0]     hit_idx;
	logic                 found_d;
	logic                 matched_d;

	assign adv       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = valid_s2;

	always_comb begin
		m_tdata = '0;
		m_tdata[NUM_LINES-1:0] = lines_s2;
		m_tdata[NUM_LINES] = found_s2;
		m_tdata[NUM_LINES+IDX_W:NUM_LINES+1] = idx_s2;
	end

	always_comb begin
		vec_d = stable_q;
		for (int i = 0; i < NUM_LINES; i++) begin
			if (!raw_s1[i]) begin
				cnt_d[i] = '0;
				vec_d[i] = 1'b0;
			end else begin
				cnt_d[i] = (cnt_q[i] < debounce_q) ? cnt_q[i] + 1'b1 : cnt_q[i];
				if (cnt_d[i] >= debounce_q) begin
					vec_d[i] = 1'b1;
				end
			end
		end

		// A first touch after all lines released restarts the settle timer.
		start_d = (stable_q == '0 && vec_d != '0) ? now_s1 : start_q;
		elapsed = now_s1 - start_d;
		if (vec_d == '0) begin
			settled_d = 1'b0;
		end else begin
			settled_d = ((stable_q == '0) ? 1'b0 : settled_q) || (elapsed > settle_q);
		end

		armed = !(matched_q && (stable_q == vec_d));
		hit = 1'b0;
		hit_idx = '0;
		for (int i = NUM_CODES - 1; i >= 0; i--) begin
			if (code_q[i] == vec_d) begin
				hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
		found_d   = (vec_d != '0) && settled_d && armed && hit;
		matched_d = ((stable_q != vec_d) ? 1'b0 : matched_q) || found_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			settle_q <= SETTLE_RST;
			for (int i = 0; i < NUM_CODES; i++) begin
				code_q[i] <= NUM_LINES'(code_reset(i));
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DEBOUNCE) begin
				debounce_q <= cfg_data[COUNT_W-1:0];
			end
			if (cfg_index == REG_SETTLE) begin
				settle_q <= cfg_data[TIME_W-1:0];
			end
			for (int i = 0; i < NUM_CODES; i++) begin
				if (cfg_index == CFG_IDX_W'(REG_CODE_BASE + i)) begin
					code_q[i] <= cfg_data[NUM_LINES-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_s1 <= s_tdata[NUM_LINES-1:0];
			now_s1 <= s_tdata[NUM_LINES+TIME_W-1:NUM_LINES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			for (int i = 0; i < NUM_LINES; i++) begin
				cnt_q[i] <= '0;
			end
			stable_q <= '0;
			matched_q <= 1'b0;
			start_q <= '0;
			settled_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (adv) begin
				for (int i = 0; i < NUM_LINES; i++) begin
					cnt_q[i] <= cnt_d[i];
				end
				stable_q <= vec_d;
				matched_q <= matched_d;
				start_q <= start_d;
				settled_q <= settled_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lines_s2 <= vec_d;
			found_s2 <= found_d;
			idx_s2 <= found_d ? hit_idx : '0;
		end
	end

	a_match_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && found_s2) |-> (lines_s2 != '0))
		else $error("Match reported for an empty vector.");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !found_s2) |-> (idx_s2 == '0))
		else $error("Match index not zero without a match.");

	a_match_once: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && found_d) |=> matched_q)
		else $error("Match flag not set after a reported match.");

	a_settled_touch: assert property (@(posedge clk) disable iff (!arst_n)
		settled_q |-> (stable_q != '0))
		else $error("Settled with all lines released.");

endmodule

>>> tb/sv/touch_chord_debounce_recognizer_core_tb.sv
// Self-checking testbench for the touch chord debouncer and recogniser core.
module touch_chord_debounce_recognizer_core_tb;
	import tcdr_pkg::*;

	localparam int MAX_WAIT    = 19;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LINES       = DEF_NUM_LINES;
	localparam int CODES       = DEF_NUM_CODES;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;
	localparam logic [3:0] CODE_DEFAULTS [CODES] = '{4'd6, 4'd13, 4'd5, 4'd10, 4'd9, 4'd11};

	typedef struct packed {
		logic [2:0] match_index;
		logic       match_found;
		logic [3:0] stable_lines;
	} chord_word_t;

	class chord_tracker;
		logic [5:0]  debounce;
		logic [15:0] settle_time;
		logic [3:0]  codes [CODES];
		logic [5:0]  counts [LINES];
		logic [3:0]  stable;
		logic        matched;
		logic [15:0] start_ms;
		logic        settled;
		chord_word_t pending_words [$];
		int unsigned mismatches;

		function new();
			debounce = 6'd32;
			settle_time = 16'd1000;
			codes = CODE_DEFAULTS;
			foreach (counts[i]) counts[i] = '0;
			stable = '0;
			matched = 1'b0;
			start_ms = '0;
			settled = 1'b0;
			mismatches = 0;
		endfunction

		function void take_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			if (idx == REG_DEBOUNCE) begin
				debounce = data[5:0];
			end else if (idx == REG_SETTLE) begin
				settle_time = data;
			end else if (idx >= REG_CODE_BASE && idx < REG_CODE_BASE + CODES) begin
				codes[idx - REG_CODE_BASE] = data[3:0];
			end
		endfunction

		function void take_sample(logic [3:0] raw, logic [15:0] now);
			logic [3:0]  prior;
			logic [3:0]  vec;
			logic [15:0] elapsed;
			chord_word_t w;
			prior = stable;
			vec = stable;
			w = '0;
			for (int i = 0; i < LINES; i++) begin
				if (!raw[i]) begin
					counts[i] = '0;
					vec[i] = 1'b0;
				end else begin
					if (counts[i] < debounce)
						counts[i] = counts[i] + 6'd1;
					if (counts[i] >= debounce)
						vec[i] = 1'b1;
				end
			end
			stable = vec;
			if (prior != vec)
				matched = 1'b0;
			if (vec == '0) begin
				settled = 1'b0;
			end else begin
				if (prior == '0) begin
					start_ms = now;
					settled = 1'b0;
				end
				elapsed = now - start_ms;
				if (elapsed > settle_time)
					settled = 1'b1;
			end
			if (vec != '0 && settled && !matched) begin
				for (int i = 0; i < CODES; i++) begin
					if (!w.match_found && codes[i] == vec) begin
						matched = 1'b1;
						w.match_found = 1'b1;
						w.match_index = 3'(i);
					end
				end
			end
			w.stable_lines = vec;
			pending_words.push_back(w);
		endfunction

		function void check_word(chord_word_t got);
			chord_word_t want;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_words.pop_front();
			if (got.stable_lines !== want.stable_lines) begin
				$display("%0t: stable_lines expected %h got %h", $time,
					want.stable_lines, got.stable_lines);
				mismatches++;
			end
			if (got.match_found !== want.match_found) begin
				$display("%0t: match_found expected %b got %b", $time,
					want.match_found, got.match_found);
				mismatches++;
			end
			if (got.match_index !== want.match_index) begin
				$display("%0t: match_index expected %0d got %0d", $time,
					want.match_index, got.match_index);
				mismatches++;
			end
		endfunction

		function int backlog();
			return pending_words.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [23:0]           s_tdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            m_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	chord_tracker tracker = new();
	bit           src_steady = 1'b0;
	bit           sink_steady = 1'b0;
	logic [15:0]  clock_ms = '0;
	logic [5:0]   phase_debounce = '0;
	logic [3:0]   phase_codes [CODES];
	int unsigned  cycle_count = 0;

	touch_chord_debounce_recognizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("touch_chord_debounce_recognizer_core_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 29) == 0)
				sink_steady = !sink_steady;
			stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			tracker.check_word(chord_word_t'(m_tdata));
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		tracker.take_write(idx, data);
	endtask

	task automatic send_sample(input logic [3:0] raw, input logic [15:0] now);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, now, raw};
		do @(posedge clk); while (s_tready !== 1'b1);
		tracker.take_sample(raw, now);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.backlog() != 0) @(posedge clk);
	endtask

	// Mostly held chords long enough to debounce, then a release,
	// with the odd glitch inside a hold and short bursts of random noise.
	task automatic play_chords(input int n_items, input int step_max);
		int         sent;
		int         hold;
		int         k;
		logic [3:0] chord;
		logic [3:0] raw;
		sent = 0;
		while (sent < n_items) begin
			src_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 4) != 0)
					chord = phase_codes[$urandom_range(0, CODES - 1)];
				else
					chord = 4'($urandom_range(1, 15));
				hold = int'(phase_debounce) + $urandom_range(1, 25);
				for (k = 0; k < hold; k++) begin
					raw = chord;
					if ($urandom_range(0, 11) == 0)
						raw = chord ^ (4'b1 << $urandom_range(0, 3));
					clock_ms += 16'($urandom_range(0, step_max));
					send_sample(raw, clock_ms);
					sent++;
				end
				hold = $urandom_range(1, 3);
				for (k = 0; k < hold; k++) begin
					clock_ms += 16'($urandom_range(0, step_max));
					send_sample(4'h0, clock_ms);
					sent++;
				end
			end else begin
				hold = $urandom_range(1, 6);
				for (k = 0; k < hold; k++) begin
					clock_ms += 16'($urandom_range(0, step_max));
					send_sample(4'($urandom_range(0, 15)), clock_ms);
					sent++;
				end
			end
		end
	endtask

	task automatic run_phase(input logic [5:0] deb, input logic [15:0] settle,
		input int step_max, input int n_items);
		int i;
		wait_drained();
		phase_debounce = deb;
		write_reg(REG_DEBOUNCE, {10'($urandom), deb});
		write_reg(REG_SETTLE, settle);
		for (i = 0; i < CODES; i++)
			write_reg(CFG_IDX_W'(REG_CODE_BASE + i), {12'($urandom), phase_codes[i]});
		cfg_valid <= 1'b0;
		play_chords(n_items, step_max);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Debounce of one and no settle time: first touch, wrap of the time.
		write_reg(REG_DEBOUNCE, 16'h0001);
		write_reg(REG_SETTLE, 16'h0000);
		cfg_valid <= 1'b0;
		send_sample(4'h0, 16'h0000);
		send_sample(4'h6, 16'h0064);
		send_sample(4'h6, 16'h0065);
		send_sample(4'h6, 16'h0066);
		send_sample(4'hF, 16'h0067);
		send_sample(4'hB, 16'h0068);
		send_sample(4'h0, 16'h0069);
		send_sample(4'hD, 16'hFFFF);
		send_sample(4'hD, 16'h0000);
		send_sample(4'h0, 16'h0001);
		wait_drained();

		// Debounce of zero, maximal settle time, an empty code and spare indexes.
		write_reg(REG_DEBOUNCE, 16'hFFC0);
		write_reg(REG_SETTLE, 16'hFFFF);
		write_reg(CFG_IDX_W'(REG_CODE_BASE), 16'hFFFF);
		write_reg(CFG_IDX_W'(REG_CODE_BASE + CODES - 1), 16'hFFF0);
		write_reg(REG_SPARE_FIRST, 16'h0001);
		write_reg(REG_SPARE_LAST, 16'hABCD);
		cfg_valid <= 1'b0;
		send_sample(4'hF, 16'h1000);
		send_sample(4'hF, 16'h9000);
		send_sample(4'hF, 16'h0FFF);
		send_sample(4'h0, 16'h2000);
		send_sample(4'h3, 16'h2001);
		wait_drained();

		// Counts built up, then the debounce lowered below them.
		write_reg(REG_DEBOUNCE, 16'h0005);
		write_reg(REG_SETTLE, 16'h0001);
		write_reg(CFG_IDX_W'(REG_CODE_BASE), 16'h0005);
		cfg_valid <= 1'b0;
		send_sample(4'h0, 16'h0000);
		send_sample(4'h5, 16'h0001);
		send_sample(4'h5, 16'h0002);
		send_sample(4'h5, 16'h0003);
		wait_drained();
		write_reg(REG_DEBOUNCE, 16'hFF02);
		cfg_valid <= 1'b0;
		send_sample(4'h5, 16'h0004);
		send_sample(4'h5, 16'h0006);
		send_sample(4'h5, 16'h0007);

		clock_ms = 16'hFF80;
		foreach (phase_codes[i]) phase_codes[i] = 4'($urandom_range(1, 15));
		run_phase(6'd1, 16'd0, 60, 60);
		foreach (phase_codes[i]) phase_codes[i] = 4'($urandom_range(1, 15));
		run_phase(6'd3, 16'($urandom_range(0, 200)), 50, 40);
		wait_drained();
		play_chords(40, 50);
		foreach (phase_codes[i]) phase_codes[i] = 4'($urandom_range(1, 15));
		run_phase(6'd63, 16'd100, 30, 80);
		phase_codes = CODE_DEFAULTS;
		run_phase(6'd32, 16'd1000, 120, 80);
		foreach (phase_codes[i]) phase_codes[i] = 4'($urandom_range(1, 15));
		run_phase(6'd2, 16'hFFFF, 65535, 50);
		foreach (phase_codes[i]) phase_codes[i] = 4'($urandom_range(1, 15));
		run_phase(6'd0, 16'd20, 15, 50);
		foreach (phase_codes[i]) phase_codes[i] = 4'($urandom_range(1, 15));
		phase_codes[0] = 4'h0;
		phase_codes[1] = 4'hF;
		run_phase(6'($urandom_range(1, 8)), 16'($urandom_range(0, 300)), 80, 60);

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.backlog() == 0)
			$display("touch_chord_debounce_recognizer_core_tb OK");
		else
			$display("touch_chord_debounce_recognizer_core_tb NOT OK");
		$finish;
	end

endmodule
